@@ rtl/dngr_pkg.sv @@
// Shared types, constants and the digit font for the decimal number glyph renderer.
package dngr_pkg;

   localparam int unsigned CFG_WIDTH = 11;
   localparam logic [CFG_WIDTH-1:0] SCREEN_WIDTH_RESET  = 11'd400;
   localparam logic [CFG_WIDTH-1:0] SCREEN_HEIGHT_RESET = 11'd240;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam int unsigned MAX_DIGITS  = 5;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [2:0]  LAST_GLYPH_ROW = 3'd5;
   localparam logic [2:0]  DASH_ROW       = 3'd3;
   localparam logic [3:0]  DASH_BITS      = 4'hF;
   localparam logic signed [12:0] GLYPH_PITCH = 13'sd5;

   // x / 10 == (x * 52429) >> 19 for every 16-bit x.
   localparam logic [15:0] RECIP_TEN   = 16'd52429;
   localparam int unsigned RECIP_SHIFT = 19;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      logic                          negative;
      logic [2:0]                    digit_count;
      digit_type [MAX_DIGITS-1:0]    digits;      // least significant digit at index 0
      logic signed [11:0]            origin_x;
      logic signed [11:0]            origin_y;
      logic [7:0]                    red;
      logic [7:0]                    green;
      logic [7:0]                    blue;
   } glyph_job_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CONVERT,
      FRONT_PUSH
   } front_state_type;

   // One 4-pixel row of a digit; bit 3 is the leftmost column.
   function automatic logic [3:0] font_row(input digit_type digit, input logic [2:0] row);
      logic [23:0] glyph;
      logic [23:0] shifted;
      case (digit)
         4'd0: glyph = 24'h699996;
         4'd1: glyph = 24'h262227;
         4'd2: glyph = 24'h69248F;
         4'd3: glyph = 24'h692196;
         4'd4: glyph = 24'h159F11;
         4'd5: glyph = 24'hF8E196;
         4'd6: glyph = 24'h68E996;
         4'd7: glyph = 24'hF12444;
         4'd8: glyph = 24'h696996;
         4'd9: glyph = 24'h697116;
         default: glyph = 24'h000000;
      endcase
      shifted = glyph >> (5'd20 - {row, 2'b00});
      return shifted[3:0];
   endfunction

endpackage

@@ rtl/dngr_front.sv @@
// Front end: accepts a number word and splits its magnitude into decimal digits.
module dngr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [15:0]          req_number,
   input  logic signed [11:0]          req_origin_x,
   input  logic signed [11:0]          req_origin_y,
   input  logic [7:0]                  req_red,
   input  logic [7:0]                  req_green,
   input  logic [7:0]                  req_blue,
   output logic                        push_valid,
   input  logic                        push_ready,
   output dngr_pkg::glyph_job_type     push_job
);

   dngr_pkg::front_state_type state_ff, state_in;
   dngr_pkg::glyph_job_type   job_ff, job_in;
   logic [15:0] mag_ff, mag_in;

   logic        accept;
   logic [31:0] product;
   logic [31:0] shifted;
   logic [15:0] quotient;
   logic [15:0] tenfold;
   logic [15:0] diff;
   logic [3:0]  remainder;
   logic        conv_done;

   assign accept    = req_valid && !req_stall;
   assign product   = {16'd0, mag_ff} * {16'd0, dngr_pkg::RECIP_TEN};
   assign shifted   = product >> dngr_pkg::RECIP_SHIFT;
   assign quotient  = shifted[15:0];
   assign tenfold   = {quotient[12:0], 3'b000} + {quotient[14:0], 1'b0};
   assign diff      = mag_ff - tenfold;
   assign remainder = diff[3:0];
   // At least one digit is always produced, so zero renders as a single 0.
   assign conv_done = (quotient == 16'd0) ||
                      (job_ff.digit_count == 3'(dngr_pkg::MAX_DIGITS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dngr_pkg::FRONT_IDLE: begin
            if (accept) state_in = dngr_pkg::FRONT_CONVERT;
         end
         dngr_pkg::FRONT_CONVERT: begin
            if (conv_done) state_in = dngr_pkg::FRONT_PUSH;
         end
         dngr_pkg::FRONT_PUSH: begin
            if (push_ready) state_in = dngr_pkg::FRONT_IDLE;
         end
         default: state_in = dngr_pkg::FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != dngr_pkg::FRONT_IDLE);
      push_valid = (state_ff == dngr_pkg::FRONT_PUSH);
      push_job   = job_ff;
   end

   always_comb begin
      job_in = job_ff;
      mag_in = mag_ff;
      if (accept) begin
         job_in.negative    = req_number[15];
         job_in.digit_count = 3'd0;
         job_in.digits      = '0;
         job_in.origin_x    = req_origin_x;
         job_in.origin_y    = req_origin_y;
         job_in.red         = req_red;
         job_in.green       = req_green;
         job_in.blue        = req_blue;
         // The negation of the most negative value reads correctly as unsigned 32768.
         mag_in = req_number[15] ? 16'(-req_number) : 16'(req_number);
      end else if (state_ff == dngr_pkg::FRONT_CONVERT) begin
         job_in.digits[job_ff.digit_count] = remainder;
         job_in.digit_count = job_ff.digit_count + 3'd1;
         mag_in = quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dngr_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      mag_ff <= mag_in;
   end

endmodule

@@ rtl/dngr_queue.sv @@
// Short job queue between the digit front end and the row generator.
module dngr_queue #(
   parameter int unsigned DEPTH = dngr_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  dngr_pkg::glyph_job_type push_job,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output dngr_pkg::glyph_job_type pop_job
);

   localparam int unsigned PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   dngr_pkg::glyph_job_type slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != CountWidth'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/dngr_back.sv @@
// Back end: steps through the glyph rows of a job, clips them and forms the byte index.
module dngr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  dngr_pkg::glyph_job_type job,
   input  logic [10:0]             screen_width,
   input  logic [10:0]             screen_height,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [12:0]      rsp_row_x,
   output logic signed [12:0]      rsp_row_y,
   output logic [3:0]              rsp_pixel_mask,
   output logic signed [23:0]      rsp_byte_index,
   output logic [7:0]              rsp_out_red,
   output logic [7:0]              rsp_out_green,
   output logic [7:0]              rsp_out_blue,
   output logic                    rsp_last_row
);

   // Row generator state.
   dngr_pkg::glyph_job_type job_ff, job_in;
   logic              busy_ff, busy_in;
   logic              dash_ff, dash_in;
   logic [2:0]        left_ff, left_in;
   logic [2:0]        row_ff, row_in;
   logic signed [12:0] cx_ff, cx_in;

   // Row stage.
   logic              s1_valid_ff;
   logic signed [12:0] s1_x_ff;
   logic signed [12:0] s1_y_ff;
   logic [3:0]        s1_bits_ff;
   logic              s1_last_ff;
   logic [7:0]        s1_red_ff, s1_green_ff, s1_blue_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic signed [12:0] rsp_row_x_ff, rsp_row_y_ff;
   logic [3:0]        rsp_pixel_mask_ff;
   logic [23:0]       rsp_byte_index_ff;
   logic [7:0]        rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic              rsp_last_ff;

   logic              adv;
   logic              step;
   logic              cur_last;
   logic              load;
   logic [2:0]        digit_sel;
   dngr_pkg::digit_type cur_digit;
   logic [3:0]        gen_bits;
   logic signed [12:0] gen_y;

   logic              y_inside;
   logic [3:0]        col_inside;
   logic [3:0]        mask;
   logic signed [24:0] product;
   logic signed [13:0] offset;
   logic signed [24:0] sum;
   logic signed [24:0] tripled;

   assign adv      = !rsp_valid_ff || !rsp_stall;
   assign step     = busy_ff && adv;
   assign cur_last = !dash_ff && (left_ff == 3'd1) && (row_ff == dngr_pkg::LAST_GLYPH_ROW);
   // A new job may start in the cycle that hands over the last row of the current one.
   assign job_ready = !busy_ff || (step && cur_last);
   assign load      = job_valid && job_ready;

   assign digit_sel = left_ff - 3'd1;
   assign cur_digit = job_ff.digits[digit_sel];
   assign gen_bits  = dash_ff ? dngr_pkg::DASH_BITS : dngr_pkg::font_row(cur_digit, row_ff);
   assign gen_y     = {job_ff.origin_y[11], job_ff.origin_y} +
                      $signed({10'd0, (dash_ff ? dngr_pkg::DASH_ROW : row_ff)});

   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      dash_in = dash_ff;
      left_in = left_ff;
      row_in  = row_ff;
      cx_in   = cx_ff;
      if (load) begin
         job_in  = job;
         busy_in = 1'b1;
         dash_in = job.negative;
         left_in = job.digit_count;
         row_in  = 3'd0;
         cx_in   = {job.origin_x[11], job.origin_x};
      end else if (step) begin
         if (cur_last) begin
            busy_in = 1'b0;
         end else if (dash_ff) begin
            dash_in = 1'b0;
            cx_in   = cx_ff + dngr_pkg::GLYPH_PITCH;
         end else if (row_ff == dngr_pkg::LAST_GLYPH_ROW) begin
            row_in  = 3'd0;
            left_in = left_ff - 3'd1;
            cx_in   = cx_ff + dngr_pkg::GLYPH_PITCH;
         end else begin
            row_in  = row_ff + 3'd1;
         end
      end
   end

   // Clipping: every column is checked against the screen; the row as a whole against height.
   always_comb begin
      logic signed [13:0] px;
      y_inside = !s1_y_ff[12] && (s1_y_ff[11:0] < {1'b0, screen_height});
      for (int c = 0; c < 4; c++) begin
         px = {s1_x_ff[12], s1_x_ff} + 14'(c);
         col_inside[3-c] = !px[13] && (px[12:0] < {2'b00, screen_width});
      end
      mask = s1_bits_ff & col_inside & {4{y_inside}};
   end

   assign product = $signed({{12{s1_x_ff[12]}}, s1_x_ff}) * $signed({14'd0, screen_height});
   assign offset  = $signed({3'b000, screen_height}) - 14'sd1 - {s1_y_ff[12], s1_y_ff};
   assign sum     = product + {{11{offset[13]}}, offset};
   assign tripled = sum + (sum <<< 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (adv) begin
            s1_valid_ff  <= busy_ff;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      dash_ff <= dash_in;
      left_ff <= left_in;
      row_ff  <= row_in;
      cx_ff   <= cx_in;
      if (adv) begin
         s1_x_ff     <= cx_ff;
         s1_y_ff     <= gen_y;
         s1_bits_ff  <= gen_bits;
         s1_last_ff  <= cur_last;
         s1_red_ff   <= job_ff.red;
         s1_green_ff <= job_ff.green;
         s1_blue_ff  <= job_ff.blue;

         rsp_row_x_ff      <= s1_x_ff;
         rsp_row_y_ff      <= s1_y_ff;
         rsp_pixel_mask_ff <= mask;
         rsp_byte_index_ff <= tripled[23:0];
         rsp_red_ff        <= s1_red_ff;
         rsp_green_ff      <= s1_green_ff;
         rsp_blue_ff       <= s1_blue_ff;
         rsp_last_ff       <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_x      = rsp_row_x_ff;
   assign rsp_row_y      = rsp_row_y_ff;
   assign rsp_pixel_mask = rsp_pixel_mask_ff;
   assign rsp_byte_index = $signed(rsp_byte_index_ff);
   assign rsp_out_red    = rsp_red_ff;
   assign rsp_out_green  = rsp_green_ff;
   assign rsp_out_blue   = rsp_blue_ff;
   assign rsp_last_row   = rsp_last_ff;

endmodule

@@ rtl/decimal_number_glyph_render_top.sv @@
// Path: front end, job queue, row generator, row stage, output register (d digits per word).
// Throughput: one glyph row per cycle unless rsp_stall holds it, 6 * d rows plus one for a
// minus sign, at most 31. The row generator sets the rate; the front end takes no new word
// until its job is pushed; a two-entry job queue lets it run ahead of the row generator.
// Reset: screen width returns to 400, height to 240, and the queue and pipeline empty.
// Top level of the decimal number glyph renderer.
module decimal_number_glyph_render_top #(
   parameter int unsigned QUEUE_DEPTH = dngr_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic [dngr_pkg::CFG_WIDTH-1:0] csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [15:0]         req_number,
   input  logic signed [11:0]         req_origin_x,
   input  logic signed [11:0]         req_origin_y,
   input  logic [7:0]                 req_red,
   input  logic [7:0]                 req_green,
   input  logic [7:0]                 req_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [12:0]         rsp_row_x,
   output logic signed [12:0]         rsp_row_y,
   output logic [3:0]                 rsp_pixel_mask,
   output logic signed [23:0]         rsp_byte_index,
   output logic [7:0]                 rsp_out_red,
   output logic [7:0]                 rsp_out_green,
   output logic [7:0]                 rsp_out_blue,
   output logic                       rsp_last_row
);

   logic [dngr_pkg::CFG_WIDTH-1:0] screen_width_ff;
   logic [dngr_pkg::CFG_WIDTH-1:0] screen_height_ff;

   logic                    push_valid;
   logic                    push_ready;
   dngr_pkg::glyph_job_type push_job;
   logic                    pop_valid;
   logic                    pop_ready;
   dngr_pkg::glyph_job_type pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= dngr_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= dngr_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_write_en) begin
         if (csr_index == dngr_pkg::CSR_SCREEN_WIDTH) begin
            screen_width_ff <= csr_wdata;
         end
         if (csr_index == dngr_pkg::CSR_SCREEN_HEIGHT) begin
            screen_height_ff <= csr_wdata;
         end
      end
   end

   dngr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_number   (req_number),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_job     (push_job)
   );

   dngr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   dngr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (pop_valid),
      .job_ready      (pop_ready),
      .job            (pop_job),
      .screen_width   (screen_width_ff),
      .screen_height  (screen_height_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_x      (rsp_row_x),
      .rsp_row_y      (rsp_row_y),
      .rsp_pixel_mask (rsp_pixel_mask),
      .rsp_byte_index (rsp_byte_index),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_last_row   (rsp_last_row)
   );

endmodule

@@ dv/dngr_row_checker.sv @@
// Checker for the glyph renderer: predicts every glyph row of a number and compares results.
module dngr_row_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [dngr_pkg::CFG_WIDTH-1:0] csr_wdata,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic signed [15:0]             req_number,
   input  logic signed [11:0]             req_origin_x,
   input  logic signed [11:0]             req_origin_y,
   input  logic [7:0]                     req_red,
   input  logic [7:0]                     req_green,
   input  logic [7:0]                     req_blue,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic signed [12:0]             rsp_row_x,
   input  logic signed [12:0]             rsp_row_y,
   input  logic [3:0]                     rsp_pixel_mask,
   input  logic signed [23:0]             rsp_byte_index,
   input  logic [7:0]                     rsp_out_red,
   input  logic [7:0]                     rsp_out_green,
   input  logic [7:0]                     rsp_out_blue,
   input  logic                           rsp_last_row,
   output int                             fail_count,
   output int                             rows_outstanding
);

   typedef struct packed {
      logic signed [12:0] x;
      logic signed [12:0] y;
      logic [3:0]         mask;
      logic [23:0]        index;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic               last;
   } glyph_row_type;

   glyph_row_type                  expected_rows[$];
   logic [dngr_pkg::CFG_WIDTH-1:0] screen_w = dngr_pkg::SCREEN_WIDTH_RESET;
   logic [dngr_pkg::CFG_WIDTH-1:0] screen_h = dngr_pkg::SCREEN_HEIGHT_RESET;
   int                             rows_seen = 0;

   initial begin
      fail_count = 0;
      rows_outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] row %0d: %s", $realtime, rows_seen, msg);
      fail_count++;
   endtask

   // Font bits of one digit row; the top row sits in the high nibble.
   function automatic logic [3:0] digit_row_bits(input int digit, input int gr);
      logic [23:0] rows;
      case (digit)
         0: rows = 24'h699996;
         1: rows = 24'h262227;
         2: rows = 24'h69248F;
         3: rows = 24'h692196;
         4: rows = 24'h159F11;
         5: rows = 24'hF8E196;
         6: rows = 24'h68E996;
         7: rows = 24'hF12444;
         8: rows = 24'h696996;
         9: rows = 24'h697116;
         default: rows = '0;
      endcase
      return rows[20 - 4 * gr +: 4];
   endfunction

   function automatic glyph_row_type clip_row(input int x, input int y, input logic [3:0] bits,
                                              input logic [7:0] red, input logic [7:0] green,
                                              input logic [7:0] blue, input logic last);
      glyph_row_type row_exp;
      int            w;
      int            h;
      int            c;
      longint        index;
      w = screen_w;
      h = screen_h;
      row_exp.mask = '0;
      for (c = 0; c < 4; c++) begin
         if (bits[3 - c] && (x + c) >= 0 && (x + c) < w && y >= 0 && y < h)
            row_exp.mask[3 - c] = 1'b1;
      end
      // The index follows the formula even for clipped rows and wraps at 24 bits.
      index = (longint'(x) * h + (h - 1 - y)) * 3;
      row_exp.x = x[12:0];
      row_exp.y = y[12:0];
      row_exp.index = index[23:0];
      row_exp.red = red;
      row_exp.green = green;
      row_exp.blue = blue;
      row_exp.last = last;
      return row_exp;
   endfunction

   function automatic void predict_glyph_rows(input logic signed [15:0] number,
                                              input logic signed [11:0] origin_x,
                                              input logic signed [11:0] origin_y,
                                              input logic [7:0] red, input logic [7:0] green,
                                              input logic [7:0] blue);
      int value;
      int mag;
      int nd;
      int pos;
      int i;
      int gr;
      int ox;
      int oy;
      int digs[5];
      value = number;
      ox = origin_x;
      oy = origin_y;
      pos = 0;
      if (value < 0) begin
         expected_rows.push_back(clip_row(ox, oy + int'(dngr_pkg::DASH_ROW),
                                          dngr_pkg::DASH_BITS, red, green, blue, 1'b0));
         pos = 1;
         mag = -value;
      end else begin
         mag = value;
      end
      nd = 0;
      do begin
         digs[nd] = mag % 10;
         mag = mag / 10;
         nd++;
      end while (mag != 0 && nd < 5);
      for (i = nd - 1; i >= 0; i--) begin
         for (gr = 0; gr < 6; gr++)
            expected_rows.push_back(clip_row(ox + pos * int'(dngr_pkg::GLYPH_PITCH), oy + gr,
                                             digit_row_bits(digs[i], gr), red, green, blue,
                                             i == 0 && gr == 5));
         pos++;
      end
   endfunction

   always @(posedge clock) begin
      glyph_row_type want;
      if (reset) begin
         expected_rows.delete();
         screen_w = dngr_pkg::SCREEN_WIDTH_RESET;
         screen_h = dngr_pkg::SCREEN_HEIGHT_RESET;
      end else begin
         if (csr_write_en) begin
            if (csr_index == dngr_pkg::CSR_SCREEN_WIDTH)
               screen_w = csr_wdata;
            else
               screen_h = csr_wdata;
         end
         if (req_valid && !req_stall)
            predict_glyph_rows(req_number, req_origin_x, req_origin_y,
                               req_red, req_green, req_blue);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               report_mismatch("result word arrived with no row expected");
            end else begin
               want = expected_rows.pop_front();
               if (rsp_row_x !== want.x)
                  report_mismatch($sformatf("row_x %0d, expected %0d", rsp_row_x, want.x));
               if (rsp_row_y !== want.y)
                  report_mismatch($sformatf("row_y %0d, expected %0d", rsp_row_y, want.y));
               if (rsp_pixel_mask !== want.mask)
                  report_mismatch($sformatf("pixel_mask %h, expected %h",
                                            rsp_pixel_mask, want.mask));
               if (rsp_byte_index !== want.index)
                  report_mismatch($sformatf("byte_index %h, expected %h",
                                            rsp_byte_index, want.index));
               if (rsp_out_red !== want.red)
                  report_mismatch($sformatf("out_red %h, expected %h", rsp_out_red, want.red));
               if (rsp_out_green !== want.green)
                  report_mismatch($sformatf("out_green %h, expected %h",
                                            rsp_out_green, want.green));
               if (rsp_out_blue !== want.blue)
                  report_mismatch($sformatf("out_blue %h, expected %h",
                                            rsp_out_blue, want.blue));
               if (rsp_last_row !== want.last)
                  report_mismatch($sformatf("last_row %b, expected %b",
                                            rsp_last_row, want.last));
            end
            rows_seen++;
         end
      end
      rows_outstanding <= expected_rows.size();
   end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the glyph renderer: clock, reset, stimulus, register settings and verdict.
module tb_top;

   localparam int CYCLE_LIMIT = 500000;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           csr_write_en = 1'b0;
   logic                           csr_index = dngr_pkg::CSR_SCREEN_WIDTH;
   logic [dngr_pkg::CFG_WIDTH-1:0] csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [15:0]             req_number = '0;
   logic signed [11:0]             req_origin_x = '0;
   logic signed [11:0]             req_origin_y = '0;
   logic [7:0]                     req_red = '0;
   logic [7:0]                     req_green = '0;
   logic [7:0]                     req_blue = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [12:0]             rsp_row_x;
   logic signed [12:0]             rsp_row_y;
   logic [3:0]                     rsp_pixel_mask;
   logic signed [23:0]             rsp_byte_index;
   logic [7:0]                     rsp_out_red;
   logic [7:0]                     rsp_out_green;
   logic [7:0]                     rsp_out_blue;
   logic                           rsp_last_row;

   int   fail_count;
   int   rows_outstanding;
   int   cycle_count = 0;
   logic idle_on = 1'b0;

   decimal_number_glyph_render_top u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_number     (req_number),
      .req_origin_x   (req_origin_x),
      .req_origin_y   (req_origin_y),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_x      (rsp_row_x),
      .rsp_row_y      (rsp_row_y),
      .rsp_pixel_mask (rsp_pixel_mask),
      .rsp_byte_index (rsp_byte_index),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_last_row   (rsp_last_row)
   );

   dngr_row_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_number       (req_number),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_x        (rsp_row_x),
      .rsp_row_y        (rsp_row_y),
      .rsp_pixel_mask   (rsp_pixel_mask),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_last_row     (rsp_last_row),
      .fail_count       (fail_count),
      .rows_outstanding (rows_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= idle_on && ($urandom_range(99) < 27);

   // The colour is packed as red, green, blue from the top byte down.
   task automatic send_word(input int number, input int ox, input int oy, input int colour);
      while (idle_on && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_number   <= number[15:0];
      req_origin_x <= ox[11:0];
      req_origin_y <= oy[11:0];
      req_red      <= colour[23:16];
      req_green    <= colour[15:8];
      req_blue     <= colour[7:0];
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly short numbers near the visible area so that clipping is exercised at every edge.
   task automatic send_random_word(input int w, input int h);
      int number;
      int ox;
      int oy;
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) begin
         number = $urandom;
      end else if (pick < 9) begin
         number = (pick < 7) ? $urandom_range(99) : $urandom_range(9999);
         if ($urandom_range(1)) number = -number;
      end else begin
         case ($urandom_range(5))
            0: number = -32768;
            1: number = 32767;
            2: number = 0;
            3: number = -1;
            4: number = 10000;
            default: number = -10000;
         endcase
      end
      ox = ($urandom_range(4) == 0) ? $urandom : int'($urandom_range(w + 40)) - 36;
      oy = ($urandom_range(4) == 0) ? $urandom : int'($urandom_range(h + 10)) - 8;
      send_word(number, ox, oy, $urandom);
   endtask

   task automatic drain_rows();
      do @(posedge clock); while (rows_outstanding != 0);
   endtask

   task automatic set_screen(input int w, input int h);
      csr_write_en <= 1'b1;
      csr_index    <= dngr_pkg::CSR_SCREEN_WIDTH;
      csr_wdata    <= w[dngr_pkg::CFG_WIDTH-1:0];
      @(posedge clock);
      csr_index    <= dngr_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata    <= h[dngr_pkg::CFG_WIDTH-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(input int w, input int h, input int count, input logic quiet);
      set_screen(w, h);
      idle_on = !quiet;
      repeat (count) send_random_word(w, h);
      req_valid <= 1'b0;
      drain_rows();
   endtask

   initial begin
      int rw;
      int rh;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      // Directed words at the reset screen size of 400 by 240.
      send_word(0, 10, 10, 24'hFF0080);
      send_word(-32768, 20, 30, 24'h123456);
      send_word(32767, 50, 50, 24'hFFFFFF);
      send_word(-1, 0, 0, 24'h000000);
      send_word(12345, 100, 100, 24'hA5A55A);
      send_word(-6789, 150, 60, 24'h5A5AA5);
      send_word(-10000, 200, 120, 24'h00FF00);
      send_word(10, -3, 40, 24'h0000FF);
      send_word(88, 397, 40, 24'hFF0000);
      send_word(7, 60, -2, 24'h808080);
      send_word(4, 60, 237, 24'h7F7F7F);
      send_word(-9, -4, 100, 24'h010203);
      send_word(100, 399, 239, 24'hFEDCBA);
      send_word(-42, -1024, -1024, 24'hFFFFFF);
      send_word(5, 2047, 2047, 24'h000000);
      send_word(3, -2048, -2048, 24'hC0FFEE);
      send_word(-32768, -20, 236, 24'h00FFFF);
      send_word(99999 - 67232, 380, 200, 24'hFFFF00);
      req_valid <= 1'b0;
      drain_rows();

      rw = $urandom_range(1, 1024);
      rh = $urandom_range(1, 1024);
      run_phase(1, 1, 40, 1'b0);
      run_phase(1024, 1024, 90, 1'b1);
      run_phase(0, 2047, 40, 1'b0);
      run_phase(2047, 0, 40, 1'b0);
      run_phase(16, 12, 80, 1'b0);
      run_phase(rw, rh, 80, 1'b0);
      run_phase(400, 240, 60, 1'b0);

      // Let any stray rows show up before the verdict.
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
